### rtl/lsi_pkg.sv
package lsi_pkg;

  // Fixed field widths.
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DSQ_W    = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MINNB_W  = 6;
  localparam int unsigned WIDX_W   = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LSI_CUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NB    = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [15:0] BOX_RST     = 16'd12288;
  localparam logic [31:0] CUTOFF_RST  = 32'd2055208;
  localparam logic [15:0] LSI_CUT_RST = 16'd1515;
  localparam logic [5:0]  MIN_NB_RST  = 6'd4;

  // Number of steps of the remainder and square-root units.
  localparam int unsigned MOD_STEPS  = 16;
  localparam int unsigned SQRT_STEPS = 16;

  typedef struct packed {
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] z_pos;
    logic        last_water;
  } in_t;

  typedef struct packed {
    logic [5:0]  water_index;
    logic [31:0] lsi_value;
    logic        too_few_neighbors;
    logic        lsi_undefined;
    logic        last_result;
  } out_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_CLR,
    S_PI_RD,
    S_PI_CAP,
    S_PJ_RD,
    S_PJ_CAP,
    S_MOD,
    S_SQ,
    S_SUM,
    S_ADDI,
    S_ADDJ,
    S_IEND,
    S_OUT_INIT,
    S_O_RD,
    S_O_CAP,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SQRT_INIT,
    S_SQRT,
    S_GAP,
    S_ACC,
    S_FIN,
    S_MUL,
    S_DIV_INIT,
    S_DIV,
    S_EMIT,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;
    logic clr_step;
    logic pi_rd;
    logic pi_cap;
    logic pj_rd;
    logic pj_cap;
    logic iter_step;
    logic sq_en;
    logic sum_en;
    logic add_i;
    logic add_j;
    logic i_end;
    logic out_init;
    logic o_cnt_rd;
    logic o_cnt_cap;
    logic scan_init;
    logic scan_rd;
    logic scan_cmp;
    logic rank_done;
    logic gap_en;
    logic acc_en;
    logic mul_en;
    logic div_start;
    logic emit;
    logic out_next;
    logic pass_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_item;
    logic n_lt2;
    logic clr_last;
    logic it_zero;
    logic pair_j_last;
    logic pair_i_last;
    logic fail;
    logic cnt_rd_zero;
    logic scan_last;
    logic rank_last;
    logic undef;
    logic out_last;
  } sts_t;

endpackage

### rtl/lsi_ram.sv
module lsi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lsi_ctrl.sv
module lsi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  lsi_pkg::sts_t sts_i,
  output lsi_pkg::cmd_t cmd_o
);

  lsi_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsi_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != lsi_pkg::S_LOAD);
  assign out_valid_o = (state_q == lsi_pkg::S_OUT);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      lsi_pkg::S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load_en = 1'b1;
          if (sts_i.last_item) begin
            state_d = lsi_pkg::S_CLR;
          end
        end
      end
      lsi_pkg::S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = sts_i.n_lt2 ? lsi_pkg::S_OUT_INIT : lsi_pkg::S_PI_RD;
        end
      end
      lsi_pkg::S_PI_RD: begin
        cmd_o.pi_rd = 1'b1;
        state_d     = lsi_pkg::S_PI_CAP;
      end
      lsi_pkg::S_PI_CAP: begin
        cmd_o.pi_cap = 1'b1;
        state_d      = lsi_pkg::S_PJ_RD;
      end
      lsi_pkg::S_PJ_RD: begin
        cmd_o.pj_rd = 1'b1;
        state_d     = lsi_pkg::S_PJ_CAP;
      end
      lsi_pkg::S_PJ_CAP: begin
        cmd_o.pj_cap = 1'b1;
        state_d      = lsi_pkg::S_MOD;
      end
      lsi_pkg::S_MOD: begin
        if (sts_i.it_zero) begin
          state_d = lsi_pkg::S_SQ;
        end else begin
          cmd_o.iter_step = 1'b1;
        end
      end
      lsi_pkg::S_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d     = lsi_pkg::S_SUM;
      end
      lsi_pkg::S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = lsi_pkg::S_ADDI;
      end
      lsi_pkg::S_ADDI: begin
        cmd_o.add_i = 1'b1;
        state_d     = lsi_pkg::S_ADDJ;
      end
      lsi_pkg::S_ADDJ: begin
        cmd_o.add_j = 1'b1;
        state_d     = sts_i.pair_j_last ? lsi_pkg::S_IEND : lsi_pkg::S_PJ_RD;
      end
      lsi_pkg::S_IEND: begin
        cmd_o.i_end = 1'b1;
        state_d     = sts_i.pair_i_last ? lsi_pkg::S_OUT_INIT : lsi_pkg::S_PI_RD;
      end
      lsi_pkg::S_OUT_INIT: begin
        cmd_o.out_init = 1'b1;
        state_d        = lsi_pkg::S_O_RD;
      end
      lsi_pkg::S_O_RD: begin
        cmd_o.o_cnt_rd = 1'b1;
        state_d        = lsi_pkg::S_O_CAP;
      end
      lsi_pkg::S_O_CAP: begin
        cmd_o.o_cnt_cap = 1'b1;
        if (sts_i.fail || sts_i.cnt_rd_zero) begin
          state_d = lsi_pkg::S_FIN;
        end else begin
          state_d = lsi_pkg::S_SCAN_INIT;
        end
      end
      lsi_pkg::S_SCAN_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d         = lsi_pkg::S_SCAN_RD;
      end
      lsi_pkg::S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = lsi_pkg::S_SCAN_CMP;
      end
      lsi_pkg::S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d = sts_i.scan_last ? lsi_pkg::S_SQRT_INIT : lsi_pkg::S_SCAN_RD;
      end
      lsi_pkg::S_SQRT_INIT: begin
        cmd_o.rank_done = 1'b1;
        state_d         = lsi_pkg::S_SQRT;
      end
      lsi_pkg::S_SQRT: begin
        if (sts_i.it_zero) begin
          state_d = lsi_pkg::S_GAP;
        end else begin
          cmd_o.iter_step = 1'b1;
        end
      end
      lsi_pkg::S_GAP: begin
        cmd_o.gap_en = 1'b1;
        state_d      = lsi_pkg::S_ACC;
      end
      lsi_pkg::S_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d = sts_i.rank_last ? lsi_pkg::S_FIN : lsi_pkg::S_SCAN_INIT;
      end
      lsi_pkg::S_FIN: begin
        state_d = (sts_i.fail || sts_i.undef) ? lsi_pkg::S_EMIT : lsi_pkg::S_MUL;
      end
      lsi_pkg::S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = lsi_pkg::S_DIV_INIT;
      end
      lsi_pkg::S_DIV_INIT: begin
        cmd_o.div_start = 1'b1;
        state_d         = lsi_pkg::S_DIV;
      end
      lsi_pkg::S_DIV: begin
        if (sts_i.it_zero) begin
          state_d = lsi_pkg::S_EMIT;
        end else begin
          cmd_o.iter_step = 1'b1;
        end
      end
      lsi_pkg::S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = lsi_pkg::S_OUT;
      end
      lsi_pkg::S_OUT: begin
        if (!out_stall_i) begin
          if (sts_i.out_last) begin
            cmd_o.pass_end = 1'b1;
            state_d        = lsi_pkg::S_LOAD;
          end else begin
            cmd_o.out_next = 1'b1;
            state_d        = lsi_pkg::S_O_RD;
          end
        end
      end
      default: begin
        state_d = lsi_pkg::S_LOAD;
      end
    endcase
  end

endmodule

### rtl/lsi_dp.sv
module lsi_dp #(
  parameter int unsigned MAX_WATERS    = 64,
  parameter int unsigned MAX_NEIGHBORS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lsi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lsi_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  lsi_pkg::in_t                      in_data_i,
  input  lsi_pkg::cmd_t                     cmd_i,
  output lsi_pkg::sts_t                     sts_o,
  output lsi_pkg::out_t                     out_data_o
);

  localparam int unsigned IW    = $clog2(MAX_WATERS);
  localparam int unsigned WC_W  = $clog2(MAX_WATERS + 1);
  localparam int unsigned NW    = $clog2(MAX_NEIGHBORS);
  localparam int unsigned CW    = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned DEPTH = MAX_WATERS * MAX_NEIGHBORS;
  localparam int unsigned DA_W  = $clog2(DEPTH);
  localparam int unsigned SW    = CW + 16;
  localparam int unsigned QW    = CW + 32;
  localparam int unsigned NUM_W = 2 * CW + 32;
  localparam int unsigned DEN_W = 2 * CW;
  localparam int unsigned ITW   = $clog2(NUM_W + 1);

  // Configuration registers.
  logic [2:0][15:0] box_q;
  logic [31:0]      cut_sq_q;
  logic [15:0]      lsi_cut_q;
  logic [5:0]       min_nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q     <= {3{lsi_pkg::BOX_RST}};
      cut_sq_q  <= lsi_pkg::CUTOFF_RST;
      lsi_cut_q <= lsi_pkg::LSI_CUT_RST;
      min_nb_q  <= lsi_pkg::MIN_NB_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsi_pkg::CFG_BOX_X:     box_q[0]  <= cfg_wdata_i[15:0];
        lsi_pkg::CFG_BOX_Y:     box_q[1]  <= cfg_wdata_i[15:0];
        lsi_pkg::CFG_BOX_Z:     box_q[2]  <= cfg_wdata_i[15:0];
        lsi_pkg::CFG_CUTOFF_SQ: cut_sq_q  <= cfg_wdata_i;
        lsi_pkg::CFG_LSI_CUT:   lsi_cut_q <= cfg_wdata_i[15:0];
        lsi_pkg::CFG_MIN_NB:    min_nb_q  <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Control registers: water count, loop indexes, failure flag.
  logic [WC_W-1:0] n_q;
  logic [IW-1:0]   w_q, i_q, j_q;
  logic            fail_q;

  // Pair datapath registers.
  logic [2:0][15:0] pi_q, a_q, sh_q, mr_q;
  logic [2:0][31:0] sqr_q;
  logic [33:0]      sum_q;
  logic             hit_q;
  logic [CW-1:0]    cnti_q, cntj_q;

  // Per-water datapath registers.
  logic [CW-1:0]    cnt_q, k_q, nl_q;
  logic [NW-1:0]    m_q, pm_q, best_m_q;
  logic [31:0]      pv_q, best_v_q;
  logic             best_ok_q;
  logic [31:0]      sv_q, sres_q, sbit_q;
  logic [15:0]      prev_r_q, g_q;
  logic [31:0]      gsq_q;
  logic             gap_ok_q;
  logic [SW-1:0]    s_q;
  logic [QW-1:0]    sq_q;
  logic [NUM_W-1:0] p1_q, p2_q, dq_q;
  logic [DEN_W-1:0] den_q, dr_q;
  logic [ITW-1:0]   it_q;
  lsi_pkg::out_t    out_q;

  // Memories.
  logic [47:0]      pos_rdata;
  logic [CW-1:0]    cnt_rdata;
  logic [31:0]      dist_rdata;
  logic             pos_we, cnt_we, dist_we;
  logic [IW-1:0]    pos_raddr, cnt_waddr, cnt_raddr;
  logic [CW-1:0]    cnt_wdata;
  logic [DA_W-1:0]  dist_waddr, dist_raddr;
  logic [31:0]      dist_wdata;
  logic             room_i, room_j;

  assign room_i = (cnti_q < CW'(MAX_NEIGHBORS));
  assign room_j = (cntj_q < CW'(MAX_NEIGHBORS));

  assign pos_we    = cmd_i.load_en && (n_q < WC_W'(MAX_WATERS));
  assign pos_raddr = cmd_i.pj_rd ? j_q : i_q;

  // Count memory port selection.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = i_q;
    cnt_wdata = cnti_q;
    if (cmd_i.clr_step) begin
      cnt_we    = 1'b1;
      cnt_waddr = w_q;
      cnt_wdata = '0;
    end else if (cmd_i.add_j) begin
      cnt_we    = hit_q && room_j;
      cnt_waddr = j_q;
      cnt_wdata = cntj_q + CW'(1);
    end else if (cmd_i.i_end) begin
      cnt_we    = 1'b1;
    end
  end
  assign cnt_raddr = cmd_i.pj_rd ? j_q : i_q;

  // Distance memory port selection; a water's list starts at index * MAX_NEIGHBORS.
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = DA_W'(DA_W'(i_q) * DA_W'(MAX_NEIGHBORS) + DA_W'(cnti_q));
    if (cmd_i.add_i) begin
      dist_we = hit_q && room_i;
    end else if (cmd_i.add_j) begin
      dist_we    = hit_q && room_j;
      dist_waddr = DA_W'(DA_W'(j_q) * DA_W'(MAX_NEIGHBORS) + DA_W'(cntj_q));
    end
  end
  assign dist_wdata = sum_q[31:0];
  assign dist_raddr = DA_W'(DA_W'(i_q) * DA_W'(MAX_NEIGHBORS) + DA_W'(m_q));

  lsi_ram #(.WIDTH(48), .DEPTH(MAX_WATERS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (n_q[IW-1:0]),
    .wdata_i ({in_data_i.x_pos, in_data_i.y_pos, in_data_i.z_pos}),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  lsi_ram #(.WIDTH(CW), .DEPTH(MAX_WATERS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  lsi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  // Combinational helpers.
  logic [2:0][15:0] pj_pos, a_new, mr_new, wrap_mag;
  logic [16:0]      mod_t;
  logic [32:0]      sq_trial;
  logic [DEN_W:0]   div_t;
  logic             v_gt_prev, v_lt_best;
  logic [15:0]      root;

  assign pj_pos = pos_rdata;
  assign root   = sres_q[15:0];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      // Absolute coordinate difference.
      a_new[ax] = (pj_pos[2-ax] >= pi_q[ax]) ? pj_pos[2-ax] - pi_q[ax]
                                              : pi_q[ax] - pj_pos[2-ax];
      // One restoring step of the remainder by the box length.
      mod_t = {mr_q[ax], sh_q[ax][15]};
      if (mod_t >= {1'b0, box_q[ax]}) begin
        mod_t = mod_t - {1'b0, box_q[ax]};
      end
      mr_new[ax] = mod_t[15:0];
      // Minimum image: fold the remainder to the nearer periodic copy.
      if (box_q[ax] == 16'd0) begin
        wrap_mag[ax] = a_q[ax];
      end else if ({mr_q[ax], 1'b0} >= {1'b0, box_q[ax]}) begin
        wrap_mag[ax] = box_q[ax] - mr_q[ax];
      end else begin
        wrap_mag[ax] = mr_q[ax];
      end
    end
  end

  assign sq_trial = {1'b0, sres_q} + {1'b0, sbit_q};
  assign div_t    = {dr_q, dq_q[NUM_W-1]};

  // Ordering of (value, slot) keys for the selection sort.
  assign v_gt_prev = (k_q == '0) || (dist_rdata > pv_q) ||
                     ((dist_rdata == pv_q) && (m_q > pm_q));
  assign v_lt_best = !best_ok_q || (dist_rdata < best_v_q) ||
                     ((dist_rdata == best_v_q) && (m_q < best_m_q));

  // Main datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      w_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      fail_q <= 1'b0;
      it_q   <= '0;
    end else begin
      // Loading.
      if (pos_we) begin
        n_q <= n_q + WC_W'(1);
      end
      if (cmd_i.load_en) begin
        w_q <= '0;
        i_q <= '0;
      end
      if (cmd_i.clr_step) begin
        w_q <= w_q + IW'(1);
      end
      if (cmd_i.pi_cap) begin
        j_q <= i_q + IW'(1);
      end
      if (cmd_i.add_j) begin
        j_q <= j_q + IW'(1);
      end
      if (cmd_i.i_end) begin
        i_q <= i_q + IW'(1);
        if (32'(cnti_q) < 32'(min_nb_q)) begin
          fail_q <= 1'b1;
        end
      end
      if (cmd_i.out_init) begin
        i_q <= '0;
      end
      if (cmd_i.out_next) begin
        i_q <= i_q + IW'(1);
      end
      if (cmd_i.pass_end) begin
        n_q    <= '0;
        fail_q <= 1'b0;
      end
      // Shared step counter of the iterative units.
      if (cmd_i.pj_cap) begin
        it_q <= ITW'(lsi_pkg::MOD_STEPS);
      end else if (cmd_i.rank_done) begin
        it_q <= ITW'(lsi_pkg::SQRT_STEPS);
      end else if (cmd_i.div_start) begin
        it_q <= ITW'(NUM_W);
      end else if (cmd_i.iter_step) begin
        it_q <= it_q - ITW'(1);
      end
    end
  end

  // Pair distance pipeline.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pi_cap) begin
      pi_q   <= {pos_rdata[15:0], pos_rdata[31:16], pos_rdata[47:32]};
      cnti_q <= cnt_rdata;
    end
    if (cmd_i.pj_cap) begin
      a_q    <= a_new;
      sh_q   <= a_new;
      mr_q   <= '0;
      cntj_q <= cnt_rdata;
    end
    if (cmd_i.iter_step) begin
      for (int ax = 0; ax < 3; ax++) begin
        mr_q[ax] <= mr_new[ax];
        sh_q[ax] <= {sh_q[ax][14:0], 1'b0};
      end
    end
    if (cmd_i.sq_en) begin
      for (int ax = 0; ax < 3; ax++) begin
        sqr_q[ax] <= wrap_mag[ax] * wrap_mag[ax];
      end
    end
    if (cmd_i.sum_en) begin
      sum_q <= 34'(sqr_q[0]) + 34'(sqr_q[1]) + 34'(sqr_q[2]);
    end
    if (cmd_i.add_i && hit_q && room_i) begin
      cnti_q <= cnti_q + CW'(1);
    end
  end

  assign hit_q = (sum_q <= 34'(cut_sq_q));

  // Per-water selection sort, square root, gap statistics and division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.o_cnt_cap) begin
      cnt_q <= cnt_rdata;
      k_q   <= '0;
      nl_q  <= '0;
      s_q   <= '0;
      sq_q  <= '0;
    end
    if (cmd_i.scan_init) begin
      m_q       <= '0;
      best_ok_q <= 1'b0;
    end
    if (cmd_i.scan_cmp) begin
      m_q <= m_q + NW'(1);
      if (v_gt_prev && v_lt_best) begin
        best_ok_q <= 1'b1;
        best_v_q  <= dist_rdata;
        best_m_q  <= m_q;
      end
    end
    if (cmd_i.rank_done) begin
      pv_q   <= best_v_q;
      pm_q   <= best_m_q;
      sv_q   <= best_v_q;
      sres_q <= '0;
      sbit_q <= 32'h4000_0000;
    end
    if (cmd_i.iter_step) begin
      if (sv_q >= sq_trial[31:0]) begin
        sv_q   <= sv_q - sq_trial[31:0];
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
      dq_q   <= {dq_q[NUM_W-2:0], (div_t >= {1'b0, den_q})};
      dr_q   <= (div_t >= {1'b0, den_q}) ? DEN_W'(div_t - {1'b0, den_q})
                                         : div_t[DEN_W-1:0];
    end
    if (cmd_i.gap_en) begin
      g_q      <= root - prev_r_q;
      gsq_q    <= (root - prev_r_q) * (root - prev_r_q);
      gap_ok_q <= (k_q != '0) && (prev_r_q <= lsi_cut_q);
    end
    if (cmd_i.acc_en) begin
      if (gap_ok_q) begin
        s_q  <= s_q + SW'(g_q);
        sq_q <= sq_q + QW'(gsq_q);
      end
      if (root <= lsi_cut_q) begin
        nl_q <= nl_q + CW'(1);
      end
      prev_r_q <= root;
      k_q      <= k_q + CW'(1);
    end
    if (cmd_i.mul_en) begin
      p1_q  <= NUM_W'(nl_q * sq_q);
      p2_q  <= NUM_W'(s_q * s_q);
      den_q <= DEN_W'(nl_q * nl_q);
    end
    if (cmd_i.div_start) begin
      dq_q <= p1_q - p2_q;
      dr_q <= '0;
    end
  end

  // Output register.
  logic undef;
  assign undef = (nl_q == '0) || (nl_q == cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.water_index       <= lsi_pkg::WIDX_W'(i_q);
      out_q.too_few_neighbors <= fail_q;
      out_q.lsi_undefined     <= !fail_q && undef;
      out_q.last_result       <= (WC_W'(i_q) + WC_W'(1) == n_q);
      if (fail_q || undef) begin
        out_q.lsi_value <= '0;
      end else if (|dq_q[NUM_W-1:32]) begin
        out_q.lsi_value <= 32'hFFFF_FFFF;
      end else begin
        out_q.lsi_value <= dq_q[31:0];
      end
    end
  end

  assign out_data_o = out_q;

  // Status.
  always_comb begin
    sts_o             = '0;
    sts_o.last_item   = in_data_i.last_water;
    sts_o.n_lt2       = (n_q < WC_W'(2));
    sts_o.clr_last    = (WC_W'(w_q) + WC_W'(1) == n_q);
    sts_o.it_zero     = (it_q == '0);
    sts_o.pair_j_last = (WC_W'(j_q) + WC_W'(1) == n_q);
    sts_o.pair_i_last = (WC_W'(i_q) + WC_W'(2) == n_q);
    sts_o.fail        = fail_q;
    sts_o.cnt_rd_zero = (cnt_rdata == '0);
    sts_o.scan_last   = (CW'(m_q) + CW'(1) == cnt_q);
    sts_o.rank_last   = (k_q + CW'(1) == cnt_q);
    sts_o.undef       = undef;
    sts_o.out_last    = (WC_W'(i_q) + WC_W'(1) == n_q);
  end

endmodule

### rtl/water_local_structure_index.sv
// Local structure index of a set of water oxygens.
// Input channel (in_valid_i / in_stall_o / in_data_i): one oxygen position per
// beat, one beat per cycle while loading. A beat with last_water set closes
// the set and starts the pass; input stays stalled until the pass has ended.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result beat per
// loaded water, in load order, last_result on the final one.
// The pass clears the neighbor counts, then visits every pair, stepping the
// 16-step remainder unit of the minimum image for each. Unless the set failed
// the neighbor minimum, per water it sorts the neighbor list by repeated
// minimum search over the distance memory and takes square roots, then, if
// the index is defined, runs a one-bit-a-step divider. A stalled result
// holds its register and the pass waits on it.
// Configuration writes go through cfg_we_i / cfg_idx_i / cfg_wdata_i and take
// effect at once; write them only between runs.
// Reset returns the registers to their defaults and the block to loading.
module water_local_structure_index #(
  parameter int unsigned MAX_WATERS    = 64,
  parameter int unsigned MAX_NEIGHBORS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsi_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lsi_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lsi_pkg::out_t                 out_data_o
);

  lsi_pkg::cmd_t cmd;
  lsi_pkg::sts_t sts;

  // Sequencer.
  lsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memories and arithmetic.
  lsi_dp #(
    .MAX_WATERS    (MAX_WATERS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

### verif/lsi_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels, predicts the per-water
// local structure index and compares every result beat with it.
module lsi_checker
  import lsi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_t                 out_data_i,
  output int                   errors_o,
  output int                   results_due_o
);

  localparam int NW = 64;
  localparam int NN = 32;

  // Shadow copy of the configuration registers.
  logic [15:0] box_len [3];
  logic [31:0] cut_sq;
  logic [15:0] lsi_lim;
  logic [5:0]  min_nb;

  // Loaded positions and neighbor lists of the current set.
  logic [15:0] pos [NW][3];
  int          loaded;
  logic [31:0] nbr [NW][NN];
  int          nbr_cnt [NW];

  out_t expected_q [$];

  initial errors_o = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  // Minimum image along one axis; a zero box length leaves the axis unwrapped.
  function automatic longint min_image(input longint d, input longint b);
    longint a, q;
    if (b == 0) return d;
    a = (d < 0) ? -d : d;
    q = (2 * a + b) / (2 * b);
    a -= q * b;
    return (d < 0) ? -a : a;
  endfunction

  function automatic logic [31:0] int_root(input logic [31:0] v);
    longint unsigned res, t;
    res = 0;
    for (int b = 15; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res[31:0];
  endfunction

  function automatic void add_nbr(input int w, input logic [31:0] dsq);
    if (nbr_cnt[w] < NN) begin
      nbr[w][nbr_cnt[w]] = dsq;
      nbr_cnt[w]++;
    end
  endfunction

  // Full pass over the loaded set: pairs, sort, roots and gap variance.
  task automatic compute_lsi();
    int n, nl, m;
    bit fail, undef;
    longint unsigned s, sq, g, val, num, den;
    longint w, dsum;
    logic [31:0] r [NN];
    logic [31:0] v;
    out_t res;
    n = loaded;
    fail = 0;
    for (int i = 0; i < NW; i++) nbr_cnt[i] = 0;
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        dsum = 0;
        for (int ax = 0; ax < 3; ax++) begin
          w = min_image(longint'(pos[j][ax]) - longint'(pos[i][ax]), longint'(box_len[ax]));
          dsum += w * w;
        end
        if (dsum <= longint'(cut_sq)) begin
          add_nbr(i, dsum[31:0]);
          add_nbr(j, dsum[31:0]);
        end
      end
      if (nbr_cnt[i] < min_nb) fail = 1;
    end
    for (int i = 0; i < n; i++) begin
      nl = 0;
      val = 0;
      undef = 0;
      if (!fail) begin
        // Insertion sort keeps tied distances.
        for (int k = 0; k < nbr_cnt[i]; k++) begin
          v = nbr[i][k];
          m = k;
          while (m > 0 && r[m-1] > v) begin
            r[m] = r[m-1];
            m--;
          end
          r[m] = v;
        end
        for (int k = 0; k < nbr_cnt[i]; k++) begin
          r[k] = int_root(r[k]);
          if (r[k] <= lsi_lim) nl++;
        end
        if (nl == 0 || nl >= nbr_cnt[i]) begin
          undef = 1;
        end else begin
          s = 0;
          sq = 0;
          for (int k = 0; k < nl; k++) begin
            g = r[k+1] - r[k];
            s += g;
            sq += g * g;
          end
          num = nl * sq - s * s;
          den = nl * nl;
          val = num / den;
          if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
        end
      end
      res.water_index       = i[5:0];
      res.lsi_value         = fail ? 32'd0 : val[31:0];
      res.too_few_neighbors = fail;
      res.lsi_undefined     = fail ? 1'b0 : undef;
      res.last_result       = (i + 1 == n);
      expected_q.push_back(res);
    end
    loaded = 0;
  endtask

  // Sample every channel at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      box_len[0] = BOX_RST;
      box_len[1] = BOX_RST;
      box_len[2] = BOX_RST;
      cut_sq     = CUTOFF_RST;
      lsi_lim    = LSI_CUT_RST;
      min_nb     = MIN_NB_RST;
      loaded     = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BOX_X:     box_len[0] = cfg_wdata_i[15:0];
          CFG_BOX_Y:     box_len[1] = cfg_wdata_i[15:0];
          CFG_BOX_Z:     box_len[2] = cfg_wdata_i[15:0];
          CFG_CUTOFF_SQ: cut_sq     = cfg_wdata_i;
          CFG_LSI_CUT:   lsi_lim    = cfg_wdata_i[15:0];
          CFG_MIN_NB:    min_nb     = cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        // Positions beyond the store are dropped.
        if (loaded < NW) begin
          pos[loaded][0] = in_data_i.x_pos;
          pos[loaded][1] = in_data_i.y_pos;
          pos[loaded][2] = in_data_i.z_pos;
          loaded++;
        end
        if (in_data_i.last_water) compute_lsi();
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("[%0t] MISMATCH unexpected result beat for water %0d", $time,
                   out_data_i.water_index);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.water_index !== want.water_index)
            report("water_index", out_data_i.water_index, want.water_index);
          if (out_data_i.lsi_value !== want.lsi_value)
            report("lsi_value", out_data_i.lsi_value, want.lsi_value);
          if (out_data_i.too_few_neighbors !== want.too_few_neighbors)
            report("too_few_neighbors", out_data_i.too_few_neighbors,
                   want.too_few_neighbors);
          if (out_data_i.lsi_undefined !== want.lsi_undefined)
            report("lsi_undefined", out_data_i.lsi_undefined, want.lsi_undefined);
          if (out_data_i.last_result !== want.last_result)
            report("last_result", out_data_i.last_result, want.last_result);
        end
      end
    end
    results_due_o = expected_q.size();
  end

endmodule

### verif/water_local_structure_index_tb.sv
`timescale 1ns / 1ps

module water_local_structure_index_tb;
  import lsi_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 330;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  int                   errors;
  int                   results_due;
  int                   cycles;
  int                   items_sent;
  int                   burst_left;
  logic [15:0]          cur_box [3];
  bit                   big_done;

  water_local_structure_index DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  lsi_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .errors_o      (errors),
    .results_due_o (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** water_local_structure_index: FAILED **");
      $finish;
    end
  end

  // Receiver stalls in stretches: none, random, rare, or mostly stalled.
  initial begin
    int mode, len;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 60);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= $urandom_range(0, 1);
          2: out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Writes every register, one per cycle, then releases the port.
  task automatic apply_config(input logic [15:0] bx, input logic [15:0] by,
                              input logic [15:0] bz, input logic [31:0] cut,
                              input logic [15:0] lim, input logic [5:0] mn);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_W-1:0]     val [6];
    idx = '{CFG_BOX_X, CFG_BOX_Y, CFG_BOX_Z, CFG_CUTOFF_SQ, CFG_LSI_CUT, CFG_MIN_NB};
    val = '{32'(bx), 32'(by), 32'(bz), cut, 32'(lim), 32'(mn)};
    for (int k = 0; k < 6; k++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[k];
      cfg_wdata <= val[k];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_box = '{bx, by, bz};
  endtask

  // One input beat, preceded by a random gap at the end of a burst.
  task automatic send_beat(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid           <= 1'b1;
    in_data.x_pos      <= x;
    in_data.y_pos      <= y;
    in_data.z_pos      <= z;
    in_data.last_water <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drops valid after a set and waits until every result has come back.
  task automatic finish_set();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [15:0] coord(input int ax, input bit noisy);
    if (noisy || cur_box[ax] == 0) return 16'($urandom);
    return 16'($urandom_range(0, cur_box[ax] - 1));
  endfunction

  task automatic random_set(input int n, input bit noisy);
    for (int i = 0; i < n; i++)
      send_beat(coord(0, noisy), coord(1, noisy), coord(2, noisy), i == n - 1);
    finish_set();
  endtask

  task automatic random_config();
    int b;
    longint bb;
    b  = $urandom_range(300, 4000);
    bb = longint'(b) * b;
    apply_config(16'(b), 16'($urandom_range(b * 3 / 4, b)), 16'($urandom_range(b * 3 / 4, b)),
                 32'($urandom_range(bb / 8, bb * 3 / 4)), 16'($urandom_range(b / 8, b)),
                 ($urandom_range(0, 5) == 0) ? 6'($urandom_range(4, 8))
                                             : 6'($urandom_range(0, 3)));
  endtask

  initial begin
    int n;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_BOX_X;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    burst_left = 0;
    big_done   = 0;
    cur_box    = '{BOX_RST, BOX_RST, BOX_RST};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration: a lone water, then tied distances across the wrap.
    send_beat(16'd100, 16'd100, 16'd100, 1'b1);
    finish_set();
    send_beat(16'd0, 16'd0, 16'd0, 1'b0);
    send_beat(16'd0, 16'd0, 16'd0, 1'b0);
    send_beat(16'd12287, 16'd12287, 16'd12287, 1'b0);
    send_beat(16'd500, 16'd0, 16'd0, 1'b0);
    send_beat(16'd0, 16'd500, 16'd12000, 1'b1);
    finish_set();

    // Widest box, a cutoff above every distance, largest index limit, no neighbor minimum.
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd3221225472, 16'hFFFF, 6'd0);
    send_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_beat(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'h8000, 16'h7FFF, 16'hAAAA, 1'b0);
    send_beat(16'h5555, 16'h0001, 16'hFFFE, 1'b1);
    finish_set();

    // Unwrapped axes, zero cutoff and index limit, strictest minimum.
    apply_config(16'd0, 16'd0, 16'd0, 32'd0, 16'd0, 6'd32);
    send_beat(16'd7, 16'd7, 16'd7, 1'b0);
    send_beat(16'd7, 16'd7, 16'd7, 1'b0);
    send_beat(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
    finish_set();

    // One axis unwrapped, small box, tight index limit.
    apply_config(16'd0, 16'd1, 16'd2000, 32'd3000000, 16'd1, 6'd1);
    for (int i = 0; i < 6; i++)
      send_beat(16'($urandom_range(0, 1500)), 16'd0, 16'($urandom_range(0, 1999)), i == 5);
    finish_set();

    // Random sets under changing settings; one oversized set overflows the store.
    while (items_sent < ITEM_TARGET) begin
      random_config();
      repeat ($urandom_range(1, 4)) begin
        if (!big_done && items_sent > 150) begin
          big_done = 1;
          random_set(66, 1'b0);
        end else begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(2, 12);
          random_set(n, $urandom_range(0, 9) == 0);
        end
      end
    end

    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("** water_local_structure_index: PASSED **");
    end else begin
      $display("** water_local_structure_index: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lsi_pkg.sv
rtl/lsi_ram.sv
rtl/lsi_ctrl.sv
rtl/lsi_dp.sv
rtl/water_local_structure_index.sv
verif/lsi_checker.sv
verif/water_local_structure_index_tb.sv
